@@ src/bsa_pkg.sv @@
// bsa_pkg: shared constants, codes and controller/datapath command types
// for the banker's safety allocator; no dependencies
package bsa_pkg;

  localparam int PROC_N = 8;
  localparam int RES_N  = 3;
  localparam int UNIT_W = 8;

  localparam int PROC_W = (PROC_N > 1) ? $clog2(PROC_N) : 1;
  // available plus every allocation must fit
  localparam int WORK_W = UNIT_W + $clog2(PROC_N + 1);

  // port field widths
  localparam int FUNC_W   = 2;
  localparam int PIDX_W   = 3;
  localparam int AMT_W    = 8;
  localparam int AMT_IO   = 3;
  localparam int STATUS_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET_AVAIL = 2'd0,
    FUNC_CLAIM     = 2'd1,
    FUNC_REQUEST   = 2'd2,
    FUNC_RELEASE   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EXCEEDS     = 3'd1,
    ST_UNSAFE      = 3'd2,
    ST_REL_EXCEEDS = 3'd3,
    ST_AVAIL_OVF   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_INIT,
    S_SCAN,
    S_UNDO,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    load_item;
    logic    set_avail;
    logic    claim;
    logic    apply_req;
    logic    apply_rel;
    logic    rollback;
    logic    scan_init;
    logic    scan_step;
    logic    row_scan;
    logic    out_load;
    status_e status;
    logic    granted;
  } bsa_cmd_t;

  typedef struct packed {
    func_e func;
    logic  proc_oor;
    logic  req_fits;
    logic  rel_alloc_ok;
    logic  rel_ovf;
    logic  pass_last;
    logic  all_done;
    logic  progress;
    logic  out_busy;
  } bsa_stat_t;

endpackage

@@ src/bsa_in_if.sv @@
// bsa_in_if: operation channel, valid/ready plus operation payload
// depends on bsa_pkg for field widths
interface bsa_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsa_pkg::FUNC_W-1:0]    func;
  logic [bsa_pkg::PIDX_W-1:0]    process_index;
  logic [bsa_pkg::AMT_W-1:0]     amount_0;
  logic [bsa_pkg::AMT_W-1:0]     amount_1;
  logic [bsa_pkg::AMT_W-1:0]     amount_2;

  modport source (
    output valid, func, process_index, amount_0, amount_1, amount_2,
    input  ready
  );
  modport sink (
    input  valid, func, process_index, amount_0, amount_1, amount_2,
    output ready
  );
endinterface

@@ src/bsa_out_if.sv @@
// bsa_out_if: result channel, valid/ready plus status and available counts
// depends on bsa_pkg for field widths
interface bsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsa_pkg::STATUS_W-1:0]  status;
  logic                          granted;
  logic [bsa_pkg::AMT_W-1:0]     avail_out_0;
  logic [bsa_pkg::AMT_W-1:0]     avail_out_1;
  logic [bsa_pkg::AMT_W-1:0]     avail_out_2;

  modport source (
    output valid, status, granted, avail_out_0, avail_out_1, avail_out_2,
    input  ready
  );
  modport sink (
    input  valid, status, granted, avail_out_0, avail_out_1, avail_out_2,
    output ready
  );
endinterface

@@ src/bsa_datapath.sv @@
// bsa_datapath: available counts, allocation and need tables, safety scan
// unit and result register; depends on bsa_pkg
module bsa_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsa_pkg::bsa_cmd_t             cmd_i,
  output bsa_pkg::bsa_stat_t            stat_o,
  input  logic [bsa_pkg::FUNC_W-1:0]    in_func_i,
  input  logic [bsa_pkg::PIDX_W-1:0]    in_pidx_i,
  input  logic [bsa_pkg::AMT_W-1:0]     in_amount_0_i,
  input  logic [bsa_pkg::AMT_W-1:0]     in_amount_1_i,
  input  logic [bsa_pkg::AMT_W-1:0]     in_amount_2_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [bsa_pkg::STATUS_W-1:0]  out_status_o,
  output logic                          out_granted_o,
  output logic [bsa_pkg::AMT_W-1:0]     out_avail_0_o,
  output logic [bsa_pkg::AMT_W-1:0]     out_avail_1_o,
  output logic [bsa_pkg::AMT_W-1:0]     out_avail_2_o
);
  import bsa_pkg::*;

  // operation registers
  func_e             op_func_q;
  logic [PROC_W-1:0] op_p_q;
  logic              op_oor_q;
  logic [UNIT_W-1:0] amt_q [RES_N];

  logic [UNIT_W-1:0] avail_q [RES_N];
  logic [UNIT_W-1:0] alloc_q [PROC_N][RES_N];
  logic [UNIT_W-1:0] need_q  [PROC_N][RES_N];

  // safety scan scratch
  logic [WORK_W-1:0] work_q [RES_N];
  logic [PROC_N-1:0] fin_q;
  logic [PROC_N-1:0] fin_nxt;
  logic [PROC_W-1:0] idx_q;
  logic              prog_q;
  logic              scan_fits;

  logic [AMT_W-1:0]  amt_raw [AMT_IO];
  logic [UNIT_W-1:0] amt_in  [RES_N];
  logic [PROC_W-1:0] row_sel;
  logic [UNIT_W-1:0] need_row  [RES_N];
  logic [UNIT_W-1:0] alloc_row [RES_N];
  logic [UNIT_W:0]   rel_sum   [RES_N];

  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_granted_q;
  logic [AMT_W-1:0]  out_avail_q [AMT_IO];
  logic [AMT_W-1:0]  avail_view  [AMT_IO];

  assign amt_raw[0] = in_amount_0_i;
  assign amt_raw[1] = in_amount_1_i;
  assign amt_raw[2] = in_amount_2_i;

  // amounts masked (or widened) to the unit width
  always_comb begin
    for (int r = 0; r < RES_N; r++) begin
      amt_in[r] = UNIT_W'(amt_raw[r]);
    end
  end

  // single table read port, shared by the operation row and the scan
  assign row_sel = cmd_i.row_scan ? idx_q : op_p_q;

  always_comb begin
    for (int r = 0; r < RES_N; r++) begin
      need_row[r]  = need_q[row_sel][r];
      alloc_row[r] = alloc_q[row_sel][r];
      rel_sum[r]   = {1'b0, avail_q[r]} + {1'b0, amt_q[r]};
    end
  end

  always_comb begin
    stat_o              = '0;
    stat_o.func         = op_func_q;
    stat_o.proc_oor     = op_oor_q;
    stat_o.req_fits     = 1'b1;
    stat_o.rel_alloc_ok = 1'b1;
    stat_o.rel_ovf      = 1'b0;
    for (int r = 0; r < RES_N; r++) begin
      if (amt_q[r] > need_row[r] || amt_q[r] > avail_q[r]) begin
        stat_o.req_fits = 1'b0;
      end
      if (amt_q[r] > alloc_row[r]) begin
        stat_o.rel_alloc_ok = 1'b0;
      end
      if (rel_sum[r][UNIT_W]) begin
        stat_o.rel_ovf = 1'b1;
      end
    end
    stat_o.pass_last = (idx_q == PROC_W'(PROC_N - 1));
    stat_o.all_done  = &fin_nxt;
    stat_o.progress  = prog_q | scan_fits;
    stat_o.out_busy  = out_valid_q & ~out_ready_i;
  end

  // one process per step: can its remaining need be met from work
  always_comb begin
    scan_fits = ~fin_q[idx_q];
    for (int r = 0; r < RES_N; r++) begin
      if (WORK_W'(need_row[r]) > work_q[r]) begin
        scan_fits = 1'b0;
      end
    end
    fin_nxt = fin_q;
    if (scan_fits) begin
      fin_nxt[idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_func_q <= func_e'(in_func_i);
      op_p_q    <= PROC_W'(in_pidx_i);
      op_oor_q  <= (int'(in_pidx_i) >= PROC_N);
      for (int r = 0; r < RES_N; r++) begin
        amt_q[r] <= amt_in[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      for (int r = 0; r < RES_N; r++) begin
        work_q[r] <= WORK_W'(avail_q[r]);
      end
      fin_q  <= '0;
      idx_q  <= '0;
      prog_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (scan_fits) begin
        for (int r = 0; r < RES_N; r++) begin
          work_q[r] <= work_q[r] + WORK_W'(alloc_row[r]);
        end
      end
      fin_q <= fin_nxt;
      if (stat_o.pass_last) begin
        idx_q  <= '0;
        prog_q <= 1'b0;
      end else begin
        idx_q  <= idx_q + PROC_W'(1);
        prog_q <= prog_q | scan_fits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RES_N; r++) begin
        avail_q[r] <= '0;
      end
      for (int p = 0; p < PROC_N; p++) begin
        for (int r = 0; r < RES_N; r++) begin
          alloc_q[p][r] <= '0;
          need_q[p][r]  <= '0;
        end
      end
    end else begin
      for (int r = 0; r < RES_N; r++) begin
        if (cmd_i.set_avail) begin
          avail_q[r] <= amt_q[r];
        end else if (cmd_i.claim) begin
          need_q[op_p_q][r]  <= amt_q[r];
          alloc_q[op_p_q][r] <= '0;
        end else if (cmd_i.apply_req) begin
          avail_q[r]         <= avail_q[r] - amt_q[r];
          alloc_q[op_p_q][r] <= alloc_row[r] + amt_q[r];
          need_q[op_p_q][r]  <= need_row[r] - amt_q[r];
        end else if (cmd_i.apply_rel) begin
          avail_q[r]         <= rel_sum[r][UNIT_W-1:0];
          alloc_q[op_p_q][r] <= alloc_row[r] - amt_q[r];
          need_q[op_p_q][r]  <= need_row[r] + amt_q[r];
        end else if (cmd_i.rollback) begin
          avail_q[r]         <= avail_q[r] + amt_q[r];
          alloc_q[op_p_q][r] <= alloc_row[r] - amt_q[r];
          need_q[op_p_q][r]  <= need_row[r] + amt_q[r];
        end
      end
    end
  end

  // unused resource lanes read as zero
  for (genvar g = 0; g < AMT_IO; g++) begin : g_view
    if (g < RES_N) begin : g_used
      assign avail_view[g] = AMT_W'(avail_q[g]);
    end else begin : g_unused
      assign avail_view[g] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q  <= cmd_i.status;
      out_granted_q <= cmd_i.granted;
      for (int g = 0; g < AMT_IO; g++) begin
        out_avail_q[g] <= avail_view[g];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_granted_o = out_granted_q;
  assign out_avail_0_o = out_avail_q[0];
  assign out_avail_1_o = out_avail_q[1];
  assign out_avail_2_o = out_avail_q[2];

endmodule

@@ src/bsa_ctrl.sv @@
// bsa_ctrl: operation sequencer, drives the datapath through commands
// depends on bsa_pkg
module bsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsa_pkg::bsa_stat_t stat_i,
  output bsa_pkg::bsa_cmd_t  cmd_o
);
  import bsa_pkg::*;

  state_e  state_q, state_d;
  status_e res_status_q, res_status_d;
  logic    res_granted_q, res_granted_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      res_status_q  <= ST_OK;
      res_granted_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      res_status_q  <= res_status_d;
      res_granted_q <= res_granted_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;
    cmd_o         = '0;
    cmd_o.status  = res_status_q;
    cmd_o.granted = res_granted_q;
    in_ready_o    = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EVAL;
        end
      end

      S_EVAL: begin
        res_granted_d = 1'b0;
        res_status_d  = ST_OK;
        state_d       = S_FINISH;
        if (stat_i.func == FUNC_SET_AVAIL) begin
          cmd_o.set_avail = 1'b1;
        end else if (stat_i.proc_oor) begin
          res_status_d = ST_EXCEEDS;
        end else begin
          case (stat_i.func)
            FUNC_CLAIM: begin
              cmd_o.claim = 1'b1;
            end
            FUNC_REQUEST: begin
              if (!stat_i.req_fits) begin
                res_status_d = ST_EXCEEDS;
              end else begin
                cmd_o.apply_req = 1'b1;
                state_d         = S_INIT;
              end
            end
            FUNC_RELEASE: begin
              if (!stat_i.rel_alloc_ok) begin
                res_status_d = ST_REL_EXCEEDS;
              end else if (stat_i.rel_ovf) begin
                res_status_d = ST_AVAIL_OVF;
              end else begin
                cmd_o.apply_rel = 1'b1;
              end
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end

      S_INIT: begin
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN;
      end

      S_SCAN: begin
        cmd_o.row_scan  = 1'b1;
        cmd_o.scan_step = 1'b1;
        if (stat_i.all_done) begin
          res_status_d  = ST_OK;
          res_granted_d = 1'b1;
          state_d       = S_FINISH;
        end else if (stat_i.pass_last && !stat_i.progress) begin
          state_d = S_UNDO;
        end
      end

      S_UNDO: begin
        cmd_o.rollback = 1'b1;
        res_status_d   = ST_UNSAFE;
        state_d        = S_FINISH;
      end

      S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/bankers_safety_allocator.sv @@
// Banker's-algorithm resource allocator. One operation beat in, one result
// beat out. Operations: set available, declare claim (sets a process's need
// and clears its allocation), request (denied with status 1 when it exceeds
// need or available, otherwise applied and kept only if the safety check
// finds an order in which every process can finish, else rolled back with
// status 2) and release (status 3 when it exceeds the allocation, status 4
// when an available count would overflow). Every result carries the
// available counts after the operation. Set, claim, release and a denied
// request go from acceptance through evaluate to finish; a request that
// reaches the safety check also passes scan init and the scan, and undo
// when rolled back. The scan visits one process per cycle through the
// single table read port, at most PROC_N passes of PROC_N steps (64 at
// eight processes). A new beat is taken as soon as the previous result sits
// in the output register, even if that result has not been taken yet.
// Depends on bsa_pkg, bsa_in_if, bsa_out_if, bsa_ctrl and bsa_datapath.
module bankers_safety_allocator (
  input  logic  clk_i,
  input  logic  rst_ni,
  bsa_in_if.sink    in_i,
  bsa_out_if.source out_o
);
  import bsa_pkg::*;

  // command and status between sequencer and datapath
  bsa_cmd_t  cmd;
  bsa_stat_t stat;

  // sequencer: idle, evaluate, scan init, scan, undo, finish
  bsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // tables, work vector, finish flags and the output register
  bsa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_func_i     (in_i.func),
    .in_pidx_i     (in_i.process_index),
    .in_amount_0_i (in_i.amount_0),
    .in_amount_1_i (in_i.amount_1),
    .in_amount_2_i (in_i.amount_2),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_status_o  (out_o.status),
    .out_granted_o (out_o.granted),
    .out_avail_0_o (out_o.avail_out_0),
    .out_avail_1_o (out_o.avail_out_1),
    .out_avail_2_o (out_o.avail_out_2)
  );

`ifndef SYNTHESIS
  // one item at a time: no second beat right after an accepted one
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready
  ) else $error("operation beat taken while the previous one is in work");

  // a kept request always reports success
  a_granted_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.granted) |-> (out_o.status == ST_OK)
  ) else $error("granted flag with a failing status");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_o.valid && !out_o.ready)
  ) else $error("result register overwritten before it was taken");

  // the scan only runs after a request was applied
  a_scan_on_request: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_init |-> $past(cmd.apply_req)
  ) else $error("safety scan started without an applied request");
`endif

endmodule
